// ===== src/tssc_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle span package
// Shared widths, pipeline geometry, payload structs and the edge setup helper.
// ----------------------------------------------------------------------------
package tssc_pkg;

   localparam int COORD_BITS  = 12;
   localparam int DIV_STAGES  = (COORD_BITS + 1) / 2;
   localparam int QUO_BITS    = 2 * DIV_STAGES;
   localparam int PROD_BITS   = 2 * COORD_BITS;
   localparam int PIPE_STAGES = DIV_STAGES + 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   wide_type;
   typedef logic [COORD_BITS-1:0]        mag_type;
   typedef logic [COORD_BITS:0]          rem_type;
   typedef logic [PROD_BITS-1:0]         prod_type;
   typedef logic [QUO_BITS-1:0]          quo_type;

   // One edge reduced to unsigned division operands plus the sign of its run.
   typedef struct packed {
      logic      neg;
      coord_type x1;
      mag_type   dx_mag;
      mag_type   dy;
      mag_type   den;
   } edge_type;

   typedef struct packed {
      logic     row_ok;
      logic     lower;
      logic     odd;
      edge_type long_edge;
      edge_type short_edge;
   } setup_type;

   // Control that rides alongside the division.
   typedef struct packed {
      logic      row_ok;
      logic      lower;
      logic      odd;
      logic      long_neg;
      coord_type long_x1;
      logic      short_neg;
      coord_type short_x1;
   } meta_type;

   function automatic edge_type make_edge(input coord_type x1, input coord_type y1,
                                          input coord_type x2, input coord_type y2,
                                          input coord_type row);
      wide_type dx;
      wide_type mag;
      wide_type dy;
      wide_type den;
      edge_type e;
      dx  = wide_type'(x2) - wide_type'(x1);
      mag = (dx < 0) ? -dx : dx;
      dy  = wide_type'(row) - wide_type'(y1);
      den = wide_type'(y2) - wide_type'(y1);
      e.neg    = dx[COORD_BITS];
      e.x1     = x1;
      e.dx_mag = mag[COORD_BITS-1:0];
      e.dy     = dy[COORD_BITS-1:0];
      e.den    = den[COORD_BITS-1:0];
      return e;
   endfunction

endpackage

// ===== src/tssc_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Three vertices and the scanline, with valid/ready flow control.
// ----------------------------------------------------------------------------
interface tssc_req_if;
   logic                valid;
   logic                ready;
   tssc_pkg::coord_type ax;
   tssc_pkg::coord_type ay;
   tssc_pkg::coord_type bx;
   tssc_pkg::coord_type by_coord;
   tssc_pkg::coord_type cx;
   tssc_pkg::coord_type cy;
   tssc_pkg::coord_type row_y;

   modport source (output valid, ax, ay, bx, by_coord, cx, cy, row_y, input ready);
   modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, row_y, output ready);
endinterface

// ===== src/tssc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Span endpoints of one scanline, with valid/ready flow control.
// ----------------------------------------------------------------------------
interface tssc_rsp_if;
   logic                valid;
   logic                ready;
   logic                row_valid;
   tssc_pkg::coord_type first_x;
   tssc_pkg::coord_type second_x;
   logic                lower_part;

   modport source (output valid, row_valid, first_x, second_x, lower_part, input ready);
   modport sink   (input valid, row_valid, first_x, second_x, lower_part, output ready);
endinterface

// ===== src/triangle_scanline_span_core.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span core
// A request passes through the setup, product, division and response stages in order.
// Throughput: one request per cycle while the response side is ready; a stage
// loads only when it is empty or the stage after it loads, so no bubble blocks a new transfer.
// Reset: synchronous, active high; clears every stage valid bit only.
// ----------------------------------------------------------------------------
module triangle_scanline_span_core (
   input  logic        clock,
   input  logic        reset,
   tssc_req_if.sink    req,
   tssc_rsp_if.source  rsp
);
   localparam int NS = tssc_pkg::PIPE_STAGES;
   localparam int DS = tssc_pkg::DIV_STAGES;

   // Stage 0 holds the sorted setup, stage 1 the two products, stages 2 to
   // DS+1 the division, and the last stage the response register.
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] stage_en;

   tssc_pkg::setup_type setup_in;
   tssc_pkg::setup_type setup_ff;
   tssc_pkg::meta_type  setup_meta;
   tssc_pkg::meta_type  prod_meta_ff;
   tssc_pkg::prod_type  long_num_ff;
   tssc_pkg::prod_type  short_num_ff;
   tssc_pkg::mag_type   long_den_ff;
   tssc_pkg::mag_type   short_den_ff;
   tssc_pkg::meta_type  div_meta_ff [DS];

   tssc_pkg::mag_type   long_q;
   tssc_pkg::mag_type   short_q;
   logic                long_rem_nz;
   logic                short_rem_nz;

   logic                row_valid_ff;
   tssc_pkg::coord_type first_x_ff;
   tssc_pkg::coord_type second_x_ff;
   logic                lower_part_ff;
   logic                row_valid_in;
   tssc_pkg::coord_type first_x_in;
   tssc_pkg::coord_type second_x_in;
   logic                lower_part_in;

   // A stage may load whenever it is empty or its own content moves on.
   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || rsp.ready;
      for (int i = NS-2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign req.ready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= (i == 0) ? req.valid : valid_ff[(i == 0) ? 0 : i-1];
            end
         end
      end
   end

   // Stage 0: vertex ordering, row tests and the edge differences.
   tssc_sort u_sort (
      .ax       (req.ax),
      .ay       (req.ay),
      .bx       (req.bx),
      .by_coord (req.by_coord),
      .cx       (req.cx),
      .cy       (req.cy),
      .row_y    (req.row_y),
      .setup    (setup_in)
   );

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         setup_ff <= setup_in;
      end
   end

   always_comb begin
      setup_meta.row_ok    = setup_ff.row_ok;
      setup_meta.lower     = setup_ff.lower;
      setup_meta.odd       = setup_ff.odd;
      setup_meta.long_neg  = setup_ff.long_edge.neg;
      setup_meta.long_x1   = setup_ff.long_edge.x1;
      setup_meta.short_neg = setup_ff.short_edge.neg;
      setup_meta.short_x1  = setup_ff.short_edge.x1;
   end

   // Stage 1: row offset times the magnitude of the edge run. A vertical
   // edge has zero run, so its quotient is zero and x stays put.
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         long_num_ff  <= tssc_pkg::prod_type'(setup_ff.long_edge.dy)
                         * tssc_pkg::prod_type'(setup_ff.long_edge.dx_mag);
         short_num_ff <= tssc_pkg::prod_type'(setup_ff.short_edge.dy)
                         * tssc_pkg::prod_type'(setup_ff.short_edge.dx_mag);
         long_den_ff  <= setup_ff.long_edge.den;
         short_den_ff <= setup_ff.short_edge.den;
         prod_meta_ff <= setup_meta;
      end
   end

   // Division stages for both edges; the control rides in parallel.
   tssc_divider u_long_div (
      .clock       (clock),
      .stage_en    (stage_en[DS+1:2]),
      .num         (long_num_ff),
      .den         (long_den_ff),
      .quotient    (long_q),
      .rem_nonzero (long_rem_nz)
   );

   tssc_divider u_short_div (
      .clock       (clock),
      .stage_en    (stage_en[DS+1:2]),
      .num         (short_num_ff),
      .den         (short_den_ff),
      .quotient    (short_q),
      .rem_nonzero (short_rem_nz)
   );

   always_ff @(posedge clock) begin
      for (int s = 0; s < DS; s++) begin
         if (stage_en[s+2]) begin
            div_meta_ff[s] <= (s == 0) ? prod_meta_ff : div_meta_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   // Final stage: a rising edge takes the ceiling, so a nonzero remainder
   // bumps the quotient; a falling edge negates a floored quotient, which is
   // already the ceiling. Endpoints swap on odd rows of the segment.
   always_comb begin
      tssc_pkg::meta_type m;
      tssc_pkg::wide_type lx;
      tssc_pkg::wide_type sx;
      m  = div_meta_ff[DS-1];
      if (m.long_neg) begin
         lx = tssc_pkg::wide_type'(m.long_x1) - tssc_pkg::wide_type'({1'b0, long_q});
      end else begin
         lx = tssc_pkg::wide_type'(m.long_x1) + tssc_pkg::wide_type'({1'b0, long_q})
              + tssc_pkg::wide_type'({1'b0, long_rem_nz});
      end
      if (m.short_neg) begin
         sx = tssc_pkg::wide_type'(m.short_x1) - tssc_pkg::wide_type'({1'b0, short_q});
      end else begin
         sx = tssc_pkg::wide_type'(m.short_x1) + tssc_pkg::wide_type'({1'b0, short_q})
              + tssc_pkg::wide_type'({1'b0, short_rem_nz});
      end
      row_valid_in  = m.row_ok;
      lower_part_in = m.row_ok && m.lower;
      if (!m.row_ok) begin
         first_x_in  = '0;
         second_x_in = '0;
      end else if (m.odd) begin
         first_x_in  = sx[tssc_pkg::COORD_BITS-1:0];
         second_x_in = lx[tssc_pkg::COORD_BITS-1:0];
      end else begin
         first_x_in  = lx[tssc_pkg::COORD_BITS-1:0];
         second_x_in = sx[tssc_pkg::COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[NS-1]) begin
         row_valid_ff  <= row_valid_in;
         first_x_ff    <= first_x_in;
         second_x_ff   <= second_x_in;
         lower_part_ff <= lower_part_in;
      end
   end

   assign rsp.valid      = valid_ff[NS-1];
   assign rsp.row_valid  = row_valid_ff;
   assign rsp.first_x    = first_x_ff;
   assign rsp.second_x   = second_x_ff;
   assign rsp.lower_part = lower_part_ff;
endmodule

// ===== src/tssc_sort.sv =====
// ----------------------------------------------------------------------------
// Vertex sort
// Orders the vertices top, middle, bottom and builds both edge operands.
// ----------------------------------------------------------------------------
module tssc_sort (
   input  tssc_pkg::coord_type ax,
   input  tssc_pkg::coord_type ay,
   input  tssc_pkg::coord_type bx,
   input  tssc_pkg::coord_type by_coord,
   input  tssc_pkg::coord_type cx,
   input  tssc_pkg::coord_type cy,
   input  tssc_pkg::coord_type row_y,
   output tssc_pkg::setup_type setup
);
   tssc_pkg::coord_type xt, yt, xm, ym, xb, yb;

   // Tie breaking follows a strict less-than chain, so a tie may leave top
   // below bottom; such a triangle simply has no valid row.
   always_comb begin
      if (ay < by_coord && ay < cy) begin
         xt = ax; yt = ay;
         if (by_coord > cy) begin
            xm = cx; ym = cy; xb = bx; yb = by_coord;
         end else begin
            xm = bx; ym = by_coord; xb = cx; yb = cy;
         end
      end else if (by_coord < ay && by_coord < cy) begin
         xt = bx; yt = by_coord;
         if (ay < cy) begin
            xm = ax; ym = ay; xb = cx; yb = cy;
         end else begin
            xm = cx; ym = cy; xb = ax; yb = ay;
         end
      end else begin
         xt = cx; yt = cy;
         if (ay < by_coord) begin
            xm = ax; ym = ay; xb = bx; yb = by_coord;
         end else begin
            xm = bx; ym = by_coord; xb = ax; yb = ay;
         end
      end
   end

   always_comb begin
      setup.row_ok    = (row_y >= yt) && (row_y < yb);
      setup.lower     = (row_y >= ym);
      setup.long_edge = tssc_pkg::make_edge(xt, yt, xb, yb, row_y);
      if (setup.lower) begin
         setup.short_edge = tssc_pkg::make_edge(xm, ym, xb, yb, row_y);
         setup.odd        = row_y[0] ^ ym[0];
      end else begin
         setup.short_edge = tssc_pkg::make_edge(xt, yt, xm, ym, row_y);
         setup.odd        = row_y[0] ^ yt[0];
      end
   end
endmodule

// ===== src/tssc_divider.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring unsigned division, two quotient bits per register stage.
// ----------------------------------------------------------------------------
module tssc_divider (
   input  logic                                 clock,
   input  logic [tssc_pkg::DIV_STAGES-1:0]      stage_en,
   input  tssc_pkg::prod_type                   num,
   input  tssc_pkg::mag_type                    den,
   output tssc_pkg::mag_type                    quotient,
   output logic                                 rem_nonzero
);
   tssc_pkg::rem_type rem_ff  [tssc_pkg::DIV_STAGES];
   tssc_pkg::quo_type low_ff  [tssc_pkg::DIV_STAGES];
   tssc_pkg::quo_type quo_ff  [tssc_pkg::DIV_STAGES];
   tssc_pkg::mag_type den_ff  [tssc_pkg::DIV_STAGES];
   tssc_pkg::rem_type rem_in  [tssc_pkg::DIV_STAGES];
   tssc_pkg::quo_type low_in  [tssc_pkg::DIV_STAGES];
   tssc_pkg::quo_type quo_in  [tssc_pkg::DIV_STAGES];

   // The quotient is known to stay below 2^QUO_BITS, so the bits above the
   // low QUO_BITS of the numerator already form a remainder below den.
   always_comb begin
      tssc_pkg::rem_type r;
      tssc_pkg::quo_type l;
      tssc_pkg::quo_type q;
      tssc_pkg::mag_type d;
      for (int s = 0; s < tssc_pkg::DIV_STAGES; s++) begin
         if (s == 0) begin
            r = tssc_pkg::rem_type'(num >> tssc_pkg::QUO_BITS);
            l = num[tssc_pkg::QUO_BITS-1:0];
            q = '0;
            d = den;
         end else begin
            r = rem_ff[s-1];
            l = low_ff[s-1];
            q = quo_ff[s-1];
            d = den_ff[s-1];
         end
         for (int k = 0; k < 2; k++) begin
            r = {r[tssc_pkg::COORD_BITS-1:0], l[tssc_pkg::QUO_BITS-1]};
            l = {l[tssc_pkg::QUO_BITS-2:0], 1'b0};
            if (r >= {1'b0, d}) begin
               r = r - {1'b0, d};
               q = {q[tssc_pkg::QUO_BITS-2:0], 1'b1};
            end else begin
               q = {q[tssc_pkg::QUO_BITS-2:0], 1'b0};
            end
         end
         rem_in[s] = r;
         low_in[s] = l;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < tssc_pkg::DIV_STAGES; s++) begin
         if (stage_en[s]) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= (s == 0) ? den : den_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign quotient    = quo_ff[tssc_pkg::DIV_STAGES-1][tssc_pkg::COORD_BITS-1:0];
   assign rem_nonzero = |rem_ff[tssc_pkg::DIV_STAGES-1];
endmodule
